[hdl/nlc_pkg.sv]
package nlc_pkg;

  localparam int LFSR_W = 15;
  localparam int CYC_W  = 10;
  localparam int CODE_W = 3;
  localparam int EXP_W  = 4;
  localparam int BASE_W = 7;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // cap on cycles taken from one transaction
  localparam int MAX_STEP_CYCLES     = 1023;
  localparam int MAX_SHIFT_EXP_DFLT  = 13;

  localparam logic [LFSR_W-1:0] SEED_VALUE = 15'h7FFF;
  localparam int SHORT_TAP = 6;

  // register word indexes (byte address / 4)
  localparam logic [1:0] REG_DIVISOR = 2'd0;
  localparam logic [1:0] REG_SHIFT   = 2'd1;
  localparam logic [1:0] REG_SHORT   = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] divisor_code;
    logic [EXP_W-1:0]  shift_clock;
    logic              short_mode;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_sts_t;

  function automatic logic [BASE_W-1:0] base_divisor(input logic [CODE_W-1:0] code);
    logic [BASE_W-1:0] b;
    case (code)
      3'd0:    b = 7'd8;
      3'd1:    b = 7'd16;
      3'd2:    b = 7'd32;
      3'd3:    b = 7'd48;
      3'd4:    b = 7'd64;
      3'd5:    b = 7'd80;
      3'd6:    b = 7'd96;
      default: b = 7'd112;
    endcase
    return b;
  endfunction

endpackage

[hdl/noise_lfsr_channel.sv]
// noise channel: 15-bit lfsr clocked by a programmable divider
// input channel (in_valid/in_ready): each transaction carries in_elapsed_cycles
//   (capped at 1023) and in_restart, which reloads the lfsr with all ones and
//   clears the divider count before the cycles are added
// output channel (out_valid/out_ready): one transaction per input, carrying
//   the lfsr contents and out_sample_high (inverse of lfsr bit 0)
// period = table[divisor_code] << (shift_clock + 1), shift_clock capped at
//   MAX_SHIFT_EXP; the apb port sets divisor_code (0x0), shift_clock (0x4)
//   and short_mode (0x8); the user writes only while the channel is idle, not enforced
// steps: on accept the item is loaded; the datapath then subtracts one
//   period and shifts the lfsr once per cycle while the count holds a full
//   period, compares once more and captures the result; shifts is
//   (count + cycles) / period, at most 64 for the shortest period and the largest
//   input, more only just after the period was shortened
// one item is worked at a time; the next is accepted as soon as the result
//   sits in the output register, even while the receiver stalls it
// a stalled result holds its register; the following item then waits in
//   the capture cycle until the output register is taken
// reset: lfsr to 0x7fff, divider count and registers to zero, no result held
module noise_lfsr_channel #(
  parameter int MAX_SHIFT_EXP = nlc_pkg::MAX_SHIFT_EXP_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [nlc_pkg::CYC_W-1:0]     in_elapsed_cycles,
  input  logic                          in_restart,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sample_high,
  output logic [nlc_pkg::LFSR_W-1:0]    out_lfsr_value,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlc_pkg::ADDR_W-1:0]    paddr,
  input  logic [nlc_pkg::DATA_W-1:0]    pwdata,
  output logic [nlc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  nlc_pkg::cfg_t    cfg;
  nlc_pkg::dp_cmd_t cmd;
  nlc_pkg::dp_sts_t sts;

  // configuration registers
  nlc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: load, subtract-and-shift loop, capture into output register
  nlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // lfsr, divider count and result register
  nlc_dp #(
    .MAX_SHIFT_EXP (MAX_SHIFT_EXP)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg),
    .in_elapsed_cycles (in_elapsed_cycles),
    .in_restart        (in_restart),
    .out_sample_high   (out_sample_high),
    .out_lfsr_value    (out_lfsr_value)
  );

  // no second item is taken while one is being worked
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // sample level follows the register bit it is derived from
  a_sample_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_high == !out_lfsr_value[0]))
    else $error("sample level does not match lfsr bit 0");

  // a new result only comes out of the capture cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished item");

endmodule

[hdl/nlc_regs.sv]
module nlc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nlc_pkg::ADDR_W-1:0]    paddr,
  input  logic [nlc_pkg::DATA_W-1:0]    pwdata,
  output logic [nlc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output nlc_pkg::cfg_t                 cfg
);

  nlc_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        nlc_pkg::REG_DIVISOR: cfg_nxt.divisor_code = pwdata[nlc_pkg::CODE_W-1:0];
        nlc_pkg::REG_SHIFT:   cfg_nxt.shift_clock  = pwdata[nlc_pkg::EXP_W-1:0];
        nlc_pkg::REG_SHORT:   cfg_nxt.short_mode   = pwdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      nlc_pkg::REG_DIVISOR: prdata = nlc_pkg::DATA_W'(cfg_r.divisor_code);
      nlc_pkg::REG_SHIFT:   prdata = nlc_pkg::DATA_W'(cfg_r.shift_clock);
      nlc_pkg::REG_SHORT:   prdata = nlc_pkg::DATA_W'(cfg_r.short_mode);
      default:              prdata = '0;
    endcase
  end

endmodule

[hdl/nlc_dp.sv]
module nlc_dp #(
  parameter int MAX_SHIFT_EXP = nlc_pkg::MAX_SHIFT_EXP_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nlc_pkg::dp_cmd_t              cmd,
  output nlc_pkg::dp_sts_t              sts,
  input  nlc_pkg::cfg_t                 cfg,
  input  logic [nlc_pkg::CYC_W-1:0]     in_elapsed_cycles,
  input  logic                          in_restart,
  output logic                          out_sample_high,
  output logic [nlc_pkg::LFSR_W-1:0]    out_lfsr_value
);

  localparam int PER_W = nlc_pkg::BASE_W + MAX_SHIFT_EXP + 1;
  localparam int WRK_W = PER_W + 1;
  localparam int SH_W  = nlc_pkg::EXP_W + 1;

  logic [nlc_pkg::LFSR_W-1:0] lfsr_r, lfsr_nxt, lfsr_adv;
  logic [WRK_W-1:0]           cnt_r, cnt_nxt, cnt_base;
  logic [PER_W-1:0]           period_r, period_nxt;
  logic [nlc_pkg::LFSR_W-1:0] res_r;
  logic [nlc_pkg::EXP_W-1:0]  exp_sat;
  logic [nlc_pkg::CYC_W-1:0]  cyc_sat;
  logic                       fb;

  // period from the current registers, exponent capped
  always_comb begin
    exp_sat = (cfg.shift_clock > nlc_pkg::EXP_W'(MAX_SHIFT_EXP)) ?
              nlc_pkg::EXP_W'(MAX_SHIFT_EXP) : cfg.shift_clock;
    period_nxt = PER_W'(nlc_pkg::base_divisor(cfg.divisor_code))
                 << ({1'b0, exp_sat} + SH_W'(1));
    cyc_sat = ({7'd0, in_elapsed_cycles} > 17'(nlc_pkg::MAX_STEP_CYCLES)) ?
              nlc_pkg::CYC_W'(nlc_pkg::MAX_STEP_CYCLES) : in_elapsed_cycles;
    cnt_base = in_restart ? '0 : cnt_r;
  end

  // one shift of the register
  always_comb begin
    fb       = lfsr_r[0] ^ lfsr_r[1];
    lfsr_adv = {fb, lfsr_r[nlc_pkg::LFSR_W-1:1]};
    if (cfg.short_mode) begin
      lfsr_adv[nlc_pkg::SHORT_TAP] = fb;
    end
  end

  always_comb begin
    lfsr_nxt = lfsr_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      lfsr_nxt = in_restart ? nlc_pkg::SEED_VALUE : lfsr_r;
      cnt_nxt  = cnt_base + WRK_W'(cyc_sat);
    end else if (cmd.step) begin
      lfsr_nxt = lfsr_adv;
      cnt_nxt  = cnt_r - {1'b0, period_r};
    end
  end

  assign sts.more = (cnt_r >= {1'b0, period_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= nlc_pkg::SEED_VALUE;
      cnt_r  <= '0;
    end else begin
      lfsr_r <= lfsr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      period_r <= period_nxt;
    end
    if (cmd.capture) begin
      res_r <= lfsr_r;
    end
  end

  assign out_lfsr_value  = res_r;
  assign out_sample_high = ~res_r[0];

endmodule

[hdl/nlc_ctrl.sv]
module nlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output nlc_pkg::dp_cmd_t  cmd,
  input  nlc_pkg::dp_sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.more) begin
          cmd.step = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

  // shift exponent cap of the instance, which keeps its default
  localparam int MAX_EXP = nlc_pkg::MAX_SHIFT_EXP_DFLT;
  // word index past the last register, writes there must change nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 156;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                       sample_high;
    logic [nlc_pkg::LFSR_W-1:0] lfsr_value;
  } noise_sample_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_t;

  // tracks the channel state and queues the sample expected per input transaction
  class lfsr_tracker;
    logic [nlc_pkg::CODE_W-1:0] divisor_code;
    logic [nlc_pkg::EXP_W-1:0]  shift_clock;
    logic                       short_mode;
    logic [nlc_pkg::LFSR_W-1:0] lfsr;
    int unsigned                count;
    int unsigned                base_table[8];
    noise_sample_t              expected_q[$];
    int unsigned                fail_count;

    function new();
      base_table = '{8, 16, 32, 48, 64, 80, 96, 112};
      divisor_code = '0;
      shift_clock = '0;
      short_mode = 1'b0;
      lfsr = nlc_pkg::SEED_VALUE;
      count = 0;
      fail_count = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [nlc_pkg::DATA_W-1:0] value);
      case (index)
        nlc_pkg::REG_DIVISOR: divisor_code = value[nlc_pkg::CODE_W-1:0];
        nlc_pkg::REG_SHIFT:   shift_clock = value[nlc_pkg::EXP_W-1:0];
        nlc_pkg::REG_SHORT:   short_mode = value[0];
        default:              ;
      endcase
    endfunction

    function void note_advance(logic [nlc_pkg::CYC_W-1:0] cycles, logic restart);
      int unsigned exp_used;
      int unsigned period;
      int unsigned total;
      int unsigned shifts;
      logic        fb;
      exp_used = (shift_clock > MAX_EXP) ? MAX_EXP : shift_clock;
      period = base_table[divisor_code] << (exp_used + 1);
      if (restart) begin
        lfsr = nlc_pkg::SEED_VALUE;
        count = 0;
      end
      total = count + cycles;
      shifts = total / period;
      count = total % period;
      repeat (shifts) begin
        fb = lfsr[0] ^ lfsr[1];
        lfsr = {fb, lfsr[nlc_pkg::LFSR_W-1:1]};
        if (short_mode) lfsr[nlc_pkg::SHORT_TAP] = fb;
      end
      expected_q.push_back('{sample_high: ~lfsr[0], lfsr_value: lfsr});
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_sample(logic sample_high, logic [nlc_pkg::LFSR_W-1:0] lfsr_value);
      noise_sample_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: sample %0b lfsr %h", sample_high, lfsr_value));
        return;
      end
      want = expected_q.pop_front();
      if (want.sample_high !== sample_high || want.lfsr_value !== lfsr_value)
        report($sformatf("mismatch: expected sample %0b lfsr %h, got sample %0b lfsr %h",
                         want.sample_high, want.lfsr_value, sample_high, lfsr_value));
    endfunction

    function int unsigned waiting();
      return expected_q.size();
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [nlc_pkg::CYC_W-1:0]    in_elapsed_cycles = '0;
  logic                         in_restart = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_sample_high;
  logic [nlc_pkg::LFSR_W-1:0]   out_lfsr_value;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [nlc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [nlc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [nlc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  lfsr_tracker tracker;

  // sender burst control, and the request for a long receiver hold-off
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 1;
  bit          hold_req = 1'b0;

  noise_lfsr_channel u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_elapsed_cycles (in_elapsed_cycles),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_high   (out_sample_high),
    .out_lfsr_value    (out_lfsr_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #1 clk = ~clk;

  // hard stop in case the channel hangs
  initial begin
    #20000000;
    $display("noise_lfsr_channel test failed");
    $finish;
  end

  // receiver: checks every result transaction, stalls on its own pattern,
  // and holds off for a long stretch when asked so that the input backs up
  initial begin : receiver
    int unsigned tick;
    int unsigned hold_left;
    rx_mode_t    mode;
    logic        next_ready;
    tick = 0;
    hold_left = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      // values seen here are the ones sampled at this edge
      if (rst_n && out_valid && out_ready)
        tracker.check_sample(out_sample_high, out_lfsr_value);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (tick % 256 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      tick++;
      case (mode)
        RX_OPEN:    next_ready = 1'b1;
        RX_LIGHT:   next_ready = ($urandom_range(0, 9) < 7);
        RX_PATTERN: next_ready = (tick % 5 != 0) && (tick % 13 != 0);
        default:    next_ready = ($urandom_range(0, 9) < 3);
      endcase
      if (hold_left != 0) begin
        next_ready = 1'b0;
        hold_left--;
      end
      out_ready <= next_ready;
    end
  end

  // register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] index, input logic [nlc_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(index, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // writes all three registers, with junk in the unused upper bits if asked
  task automatic apply_setting(input int unsigned code, input int unsigned exp_sel,
                               input int unsigned short_sel, input bit junk);
    logic [nlc_pkg::DATA_W-1:0] upper;
    upper = junk ? $urandom : '0;
    write_reg(nlc_pkg::REG_DIVISOR,
              {upper[nlc_pkg::DATA_W-1:nlc_pkg::CODE_W], code[nlc_pkg::CODE_W-1:0]});
    write_reg(nlc_pkg::REG_SHIFT,
              {upper[nlc_pkg::DATA_W-1:nlc_pkg::EXP_W], exp_sel[nlc_pkg::EXP_W-1:0]});
    write_reg(nlc_pkg::REG_SHORT, {upper[nlc_pkg::DATA_W-1:1], short_sel[0]});
  endtask

  // offers one input transaction and holds it until taken; gaps between bursts
  task automatic send_item(input logic [nlc_pkg::CYC_W-1:0] cycles, input logic restart);
    in_valid <= 1'b1;
    in_elapsed_cycles <= cycles;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_advance(cycles, restart);
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // channel idle: every result taken, then a few spare cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [nlc_pkg::CYC_W-1:0] pick_cycles();
    case ($urandom_range(0, 9))
      0:       return nlc_pkg::CYC_W'(nlc_pkg::MAX_STEP_CYCLES);
      1:       return nlc_pkg::CYC_W'($urandom_range(0, 31));
      default: return nlc_pkg::CYC_W'($urandom_range(0, nlc_pkg::MAX_STEP_CYCLES));
    endcase
  endfunction

  // mostly short periods so that the register keeps moving
  function automatic int unsigned pick_exp();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 2);
    if (r < 9) return $urandom_range(3, 6);
    return $urandom_range(7, 15);
  endfunction

  initial begin : stimulus
    int unsigned phase;
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting, period 16: no shift, partial count, exact period, restart
    gaps_on = 1'b0;
    send_item(10'd0, 1'b0);
    send_item(10'd15, 1'b0);
    send_item(10'd1, 1'b0);
    send_item(10'd16, 1'b0);
    send_item(10'd1023, 1'b0);
    send_item(10'd0, 1'b1);
    send_item(10'd1023, 1'b1);
    send_item(10'd513, 1'b0);
    settle();

    // 7-bit feedback
    write_reg(nlc_pkg::REG_SHORT, 32'h0000_0001);
    send_item(10'd1023, 1'b0);
    send_item(10'd1023, 1'b0);
    send_item(10'd1023, 1'b1);
    settle();

    // longest period, exponent above the cap: count builds up with no shifts
    apply_setting(7, 15, 0, 1'b1);
    repeat (4) send_item(10'd1023, 1'b0);
    settle();
    write_reg(nlc_pkg::REG_SHIFT, 32'hFFFF_FFFE);
    send_item(10'd1023, 1'b0);
    settle();

    // shortest period straight after: the stored count pays out all its shifts
    apply_setting(0, 0, 1, 1'b0);
    send_item(10'd0, 1'b0);
    settle();

    // write past the last register must leave the setting alone
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_item(10'd700, 1'b0);
    settle();

    // random phases, each with its own setting and sender behaviour
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       apply_setting(7, 0, 1, 1'b0);
        1:       apply_setting(0, 0, 0, 1'b1);
        2:       apply_setting(7, 13, 1, 1'b0);
        default: apply_setting($urandom_range(0, 7), pick_exp(), $urandom_range(0, 1),
                               $urandom_range(0, 3) == 0);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 24);
      // back-pressure phase: the receiver goes quiet while items keep coming
      if (phase == 3) begin
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_item(pick_cycles(), $urandom_range(0, 24) == 0);
      settle();
    end

    tracker.report_leftover();
    if (tracker.fail_count == 0)
      $display("noise_lfsr_channel test passed");
    else
      $display("noise_lfsr_channel test failed");
    $finish;
  end

endmodule
